// ===== rtl/srle_pkg.sv =====
// shared types, constants and tables of the sparse bitfield run-length decoder
package srle_pkg;

  localparam int INDEX_ENTRY_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH_DEF       = 2;
  // trailer length field covers up to seven entries of at most sixteen bytes
  localparam int TRAIL_W               = 7;
  localparam int CFG_DATA_W            = 32;
  localparam int CFG_INDEX_W           = 1;

  localparam logic [31:0] CAPACITY_RESET = 32'd131072;

  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_CAPACITY   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_BIG_ENDIAN = 1'b1;

  typedef struct packed {
    logic [7:0]  in_byte;
    logic        frame_start;
    logic [31:0] frame_bytes;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_value;
    logic [31:0] repeat_count;
    logic        frame_end;
    logic        truncated;
  } out_t;

  typedef struct packed {
    logic [31:0] capacity;
    logic        big_endian;
  } cfg_t;

  typedef enum logic [2:0] {
    TK_RUN,
    TK_LIT,
    TK_PAIR,
    TK_BIT,
    TK_LONG
  } token_kind_t;

  typedef struct packed {
    logic               is_start;
    logic [7:0]         byte_val;
    token_kind_t        kind;
    logic [6:0]         arg;
    logic [7:0]         single_val;
    logic [31:0]        payload_len;
    logic [TRAIL_W-1:0] trail_len;
  } class_t;

  function automatic logic [7:0] pair_mask(input logic [4:0] idx);
    logic [7:0] m;
    unique case (idx)
      5'd0:  m = 8'h03;
      5'd1:  m = 8'h05;
      5'd2:  m = 8'h06;
      5'd3:  m = 8'h09;
      5'd4:  m = 8'h0A;
      5'd5:  m = 8'h0C;
      5'd6:  m = 8'h11;
      5'd7:  m = 8'h12;
      5'd8:  m = 8'h14;
      5'd9:  m = 8'h18;
      5'd10: m = 8'h21;
      5'd11: m = 8'h22;
      5'd12: m = 8'h24;
      5'd13: m = 8'h28;
      5'd14: m = 8'h30;
      5'd15: m = 8'h41;
      5'd16: m = 8'h42;
      5'd17: m = 8'h44;
      5'd18: m = 8'h48;
      5'd19: m = 8'h50;
      5'd20: m = 8'h60;
      5'd21: m = 8'h81;
      5'd22: m = 8'h82;
      5'd23: m = 8'h84;
      5'd24: m = 8'h88;
      5'd25: m = 8'h90;
      5'd26: m = 8'hA0;
      5'd27: m = 8'hC0;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/srle_front.sv =====
// input stage: accepts words, classifies tokens and sizes the frame
module srle_front #(
  parameter int INDEX_ENTRY_BYTES = srle_pkg::INDEX_ENTRY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srle_pkg::in_t     in_word,
  output logic              push,
  output srle_pkg::class_t  push_data,
  input  logic              q_full
);

  logic                           fv_r;
  srle_pkg::class_t               fe_r;
  srle_pkg::class_t               fe_nxt;
  logic [srle_pkg::TRAIL_W-1:0]   trail_raw;
  logic [srle_pkg::TRAIL_W-1:0]   fb_lo;
  logic                           clamp;
  logic [7:0]                     c;

  assign push      = fv_r && !q_full;
  assign in_ready  = !fv_r || push;
  assign push_data = fe_r;

  always_comb begin
    c         = in_word.in_byte;
    trail_raw = srle_pkg::TRAIL_W'(int'(c[2:0]) * INDEX_ENTRY_BYTES);
    fb_lo     = in_word.frame_bytes[srle_pkg::TRAIL_W-1:0];
    clamp     = (in_word.frame_bytes[31:srle_pkg::TRAIL_W] == '0) && (trail_raw >= fb_lo);

    fe_nxt.is_start   = in_word.frame_start;
    fe_nxt.byte_val   = c;
    fe_nxt.kind       = srle_pkg::TK_RUN;
    fe_nxt.arg        = c[6:0];
    fe_nxt.single_val = 8'hFF;
    priority if (!c[7]) begin
      fe_nxt.kind = srle_pkg::TK_RUN;
    end else if (!c[6]) begin
      fe_nxt.kind = srle_pkg::TK_LIT;
      fe_nxt.arg  = {1'b0, c[5:0]};
    end else if (!c[5]) begin
      fe_nxt.kind       = srle_pkg::TK_PAIR;
      fe_nxt.single_val = ~srle_pkg::pair_mask(c[4:0]);
    end else if (!c[4]) begin
      fe_nxt.kind       = srle_pkg::TK_BIT;
      fe_nxt.single_val = c[3] ? 8'hFF : ~(8'h01 << c[2:0]);
    end else begin
      fe_nxt.kind = srle_pkg::TK_LONG;
      fe_nxt.arg  = {3'b000, c[3:0]};
    end

    if (clamp) begin
      fe_nxt.payload_len = '0;
      fe_nxt.trail_len   = (fb_lo == '0) ? '0 : fb_lo - 1'b1;
    end else begin
      fe_nxt.payload_len = in_word.frame_bytes - (32'(trail_raw) + 32'd1);
      fe_nxt.trail_len   = trail_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fe_r <= fe_nxt;
    end
  end

endmodule

// ===== rtl/srle_fifo.sv =====
// short queue of classified words between front and back
module srle_fifo #(
  parameter int DEPTH = srle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srle_pkg::class_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output srle_pkg::class_t  pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  srle_pkg::class_t   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/srle_back.sv =====
// decode state machine and result register
module srle_back (
  input  logic              clk,
  input  logic              rst_n,
  input  srle_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  srle_pkg::class_t  q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output srle_pkg::out_t    out_word
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TOKEN,
    PH_LITERAL,
    PH_LENGTH,
    PH_SKIP
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [31:0]                   payload_r, payload_nxt;
  logic [srle_pkg::TRAIL_W-1:0]  trailer_r, trailer_nxt;
  logic [31:0]                   cap_r, cap_nxt;
  logic [5:0]                    literal_r, literal_nxt;
  logic [3:0]                    len_left_r, len_left_nxt;
  logic [3:0]                    len_pos_r, len_pos_nxt;
  logic [63:0]                   accum_r, accum_nxt;
  logic                          short_r, short_nxt;
  logic                          out_valid_r;
  srle_pkg::out_t                out_word_r;

  logic                          item_hit;
  logic [7:0]                    item_val;
  logic [31:0]                   item_cnt;
  logic                          use_dec;
  logic [31:0]                   dec;
  logic                          run_go;
  logic [63:0]                   run_len;
  logic [31:0]                   run_n;
  logic                          res_end;
  logic                          res_valid;
  srle_pkg::out_t                res_word;

  assign pop       = !q_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    phase_nxt    = phase_r;
    payload_nxt  = payload_r;
    trailer_nxt  = trailer_r;
    cap_nxt      = cap_r;
    literal_nxt  = literal_r;
    len_left_nxt = len_left_r;
    len_pos_nxt  = len_pos_r;
    accum_nxt    = accum_r;
    short_nxt    = short_r;
    item_hit     = 1'b0;
    item_val     = 8'h00;
    item_cnt     = 32'd0;
    use_dec      = 1'b0;
    dec          = 32'd0;
    run_go       = 1'b0;
    run_len      = 64'd0;
    run_n        = 32'd0;
    res_end      = 1'b0;

    if (pop) begin
      if (q_data.is_start) begin
        payload_nxt  = q_data.payload_len;
        trailer_nxt  = q_data.trail_len;
        cap_nxt      = cfg.capacity;
        literal_nxt  = '0;
        len_left_nxt = '0;
        len_pos_nxt  = '0;
        accum_nxt    = '0;
        short_nxt    = 1'b0;
        phase_nxt    = PH_TOKEN;
      end else if (phase_r != PH_IDLE) begin
        if (payload_r != '0) begin
          payload_nxt = payload_r - 1'b1;
          use_dec     = 1'b1;
          unique case (phase_r)
            PH_TOKEN: begin
              if (cap_r == '0) begin
                short_nxt = 1'b1;
                phase_nxt = PH_SKIP;
              end else begin
                unique case (q_data.kind)
                  srle_pkg::TK_RUN: begin
                    run_go  = 1'b1;
                    run_len = 64'(q_data.arg);
                  end
                  srle_pkg::TK_LIT: begin
                    literal_nxt = q_data.arg[5:0];
                    if (q_data.arg[5:0] != '0) begin
                      phase_nxt = PH_LITERAL;
                    end
                  end
                  srle_pkg::TK_PAIR, srle_pkg::TK_BIT: begin
                    item_hit = 1'b1;
                    item_val = q_data.single_val;
                    item_cnt = 32'd1;
                    dec      = 32'd1;
                  end
                  srle_pkg::TK_LONG: begin
                    if (32'(q_data.arg[3:0]) >= payload_r) begin
                      short_nxt = 1'b1;
                      phase_nxt = PH_SKIP;
                    end else if (q_data.arg[3:0] != '0) begin
                      len_left_nxt = q_data.arg[3:0];
                      len_pos_nxt  = '0;
                      accum_nxt    = '0;
                      phase_nxt    = PH_LENGTH;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            PH_LITERAL: begin
              if (cap_r == '0) begin
                short_nxt = 1'b1;
                phase_nxt = PH_SKIP;
              end else begin
                item_hit    = 1'b1;
                item_val    = q_data.byte_val;
                item_cnt    = 32'd1;
                dec         = 32'd1;
                literal_nxt = literal_r - 1'b1;
                if (literal_r == 6'd1) begin
                  phase_nxt = PH_TOKEN;
                end
              end
            end
            PH_LENGTH: begin
              if (cfg.big_endian) begin
                accum_nxt = {accum_r[55:0], q_data.byte_val};
              end else if (!len_pos_r[3]) begin
                for (int i = 0; i < 8; i++) begin
                  if (len_pos_r[2:0] == 3'(i)) begin
                    accum_nxt[8*i +: 8] = accum_r[8*i +: 8] | q_data.byte_val;
                  end
                end
              end
              if (len_pos_r != 4'd15) begin
                len_pos_nxt = len_pos_r + 1'b1;
              end
              len_left_nxt = len_left_r - 1'b1;
              if (len_left_r == 4'd1) begin
                run_go    = 1'b1;
                run_len   = accum_nxt;
                phase_nxt = PH_TOKEN;
              end
            end
            default: begin
            end
          endcase
        end else if (trailer_r != '0) begin
          trailer_nxt = trailer_r - 1'b1;
        end
      end

      if (run_go) begin
        run_n = ((run_len[63:32] == '0) && (run_len[31:0] < cap_r)) ? run_len[31:0] : cap_r;
        dec   = run_n;
        if (run_n != '0) begin
          item_hit = 1'b1;
          item_val = 8'hFF;
          item_cnt = run_n;
        end
      end
      if (use_dec) begin
        cap_nxt = cap_r - dec;
      end

      if ((q_data.is_start || phase_r != PH_IDLE) && payload_nxt == '0 && trailer_nxt == '0) begin
        res_end   = 1'b1;
        phase_nxt = PH_IDLE;
      end
    end

    res_valid             = pop && (item_hit || res_end);
    res_word.out_value    = item_val;
    res_word.repeat_count = item_cnt;
    res_word.frame_end    = res_end;
    res_word.truncated    = res_end && short_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      payload_r   <= '0;
      trailer_r   <= '0;
      cap_r       <= '0;
      literal_r   <= '0;
      len_left_r  <= '0;
      len_pos_r   <= '0;
      accum_r     <= '0;
      short_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      payload_r  <= payload_nxt;
      trailer_r  <= trailer_nxt;
      cap_r      <= cap_nxt;
      literal_r  <= literal_nxt;
      len_left_r <= len_left_nxt;
      len_pos_r  <= len_pos_nxt;
      accum_r    <= accum_nxt;
      short_r    <= short_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= res_word;
    end
  end

endmodule

// ===== rtl/sparse_bitfield_rle_decoder_core.sv =====
// top level of the sparse bitfield run-length decoder
//
//  channel   ports                                  direction
//  input     in_valid / in_ready / in_word          in, one compressed byte per word
//  result    out_valid / out_ready / out_word       out, value with repeat count
//  config    cfg_we / cfg_index / cfg_wdata         in, write only
//
// one word per cycle in, at most one out, unless stalled; a word passes
// front register, queue and result register before any result is valid
// the back decodes (token, counters, clamp) once per cycle on each pop
// reset: synchronous, active low; capacity 131072, little endian lengths
// input and result sides stall independently through the queue
module sparse_bitfield_rle_decoder_core #(
  parameter int INDEX_ENTRY_BYTES = srle_pkg::INDEX_ENTRY_BYTES_DEF,
  parameter int QUEUE_DEPTH       = srle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  srle_pkg::in_t                    in_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output srle_pkg::out_t                   out_word,
  input  logic                             cfg_we,
  input  logic [srle_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srle_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  srle_pkg::cfg_t    cfg_r;
  logic              push;
  srle_pkg::class_t  push_data;
  logic              q_full;
  logic              q_empty;
  logic              pop;
  srle_pkg::class_t  pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity   <= srle_pkg::CAPACITY_RESET;
      cfg_r.big_endian <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == srle_pkg::REG_OUTPUT_CAPACITY) begin
        cfg_r.capacity <= cfg_wdata[31:0];
      end
      if (cfg_index == srle_pkg::REG_LENGTH_BIG_ENDIAN) begin
        cfg_r.big_endian <= cfg_wdata[0];
      end
    end
  end

  srle_front #(
    .INDEX_ENTRY_BYTES(INDEX_ENTRY_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .push     (push),
    .push_data(push_data),
    .q_full   (q_full)
  );

  srle_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_data (pop_data)
  );

  srle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule

// ===== rtl/srle_checker.sv =====
// port checker for the decoder top level and its bind
module srle_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input srle_pkg::in_t  in_word,
  input logic           out_valid,
  input logic           out_ready,
  input srle_pkg::out_t out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_trunc_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.frame_end |-> !out_word.truncated)
    else $error("truncated without frame end");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.frame_end |-> out_word.repeat_count != 32'd0)
    else $error("empty result inside a frame");

  a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.repeat_count == 32'd0 |->
      out_word.out_value == 8'h00 && out_word.frame_end)
    else $error("zero count result is not a bare end marker");

endmodule

bind sparse_bitfield_rle_decoder_core srle_checker u_srle_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);
